FILE: rtl/sclen_pkg.sv
// ----------------------------------------------------------------------------
// sclen_pkg
// shared types for the signal curve length core
// ----------------------------------------------------------------------------
package sclen_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROOT,
        ST_ACCUM,
        ST_EMIT
    } state_t;

endpackage

FILE: rtl/signal_curve_length_core.sv
// ----------------------------------------------------------------------------
// signal_curve_length_core
// arc length of a sampled signal: sums floor(sqrt(d*d + 1)) in fixed point
// ----------------------------------------------------------------------------
// the first sample of a sequence is only stored (and goes to ST_EMIT if it
// ends it); every later sample runs the bit-serial root loop, which resolves
// one root bit a cycle, then ST_ACCUM, and then ST_EMIT when marked last.
// s_tready is low while an item is in work; a result in m_* waits for m_tready.
// aresetn (synchronous, active low) clears the sum, the previous sample and
// the output valid.
module signal_curve_length_core #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int FRAC_BITS    = 8,
    parameter int SUM_WIDTH    = 40
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,  // sample
    input  logic                                    s_tlast,   // last
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [((SUM_WIDTH + 7) / 8) * 8 - 1:0]  m_tdata,   // length
    output logic [0:0]                              m_tuser    // saturated
);
    import sclen_pkg::*;

    localparam int TD_OUT_W = ((SUM_WIDTH + 7) / 8) * 8;
    localparam int TERM_W   = SAMPLE_WIDTH + 1;
    localparam int ROOT_W   = FRAC_BITS + 1;
    localparam int P_W      = SAMPLE_WIDTH + FRAC_BITS + 3;
    localparam int CNT_W    = $clog2(FRAC_BITS + 2);
    localparam int ACC_W    = ((SUM_WIDTH > TERM_W) ? SUM_WIDTH : TERM_W) + 1;
    localparam logic [P_W-1:0]       LIMIT   = P_W'(1) << (2 * FRAC_BITS);
    localparam logic [SUM_WIDTH-1:0] SUM_MAX = {SUM_WIDTH{1'b1}};

    state_t                  state_reg, state_next;
    logic [SAMPLE_WIDTH-1:0] prev_reg, prev_next;
    logic                    have_prev_reg, have_prev_next;
    logic [SUM_WIDTH-1:0]    sum_reg, sum_next;
    logic                    sat_reg, sat_next;
    logic                    last_reg, last_next;
    logic                    add_reg, add_next;
    logic [SAMPLE_WIDTH-1:0] mag_reg, mag_next;
    logic [ROOT_W-1:0]       e_reg, e_next;
    logic [P_W-1:0]          p_reg, p_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    m_valid_reg, m_valid_next;
    logic [SUM_WIDTH-1:0]    m_len_reg, m_len_next;
    logic                    m_sat_reg, m_sat_next;

    logic [SAMPLE_WIDTH-1:0] cur;
    logic [P_W-1:0]          step_base;
    logic [P_W-1:0]          p_try;
    logic [ACC_W-1:0]        acc;
    logic                    acc_ovf;
    logic                    out_free;

    // offset binary keeps signed order in unsigned compares
    assign cur = {~s_tdata[SAMPLE_WIDTH-1], s_tdata[SAMPLE_WIDTH-2:0]};

    // trying bit b of e: e*(2m+e) grows by (2m + 2e + 2^b) << b
    assign step_base = (P_W'(mag_reg) << 1) + (P_W'(e_reg) << 1) + (P_W'(1) << cnt_reg);
    assign p_try     = p_reg + (step_base << cnt_reg);

    assign acc     = ACC_W'(sum_reg) + ACC_W'(TERM_W'(mag_reg) + TERM_W'(e_reg));
    assign acc_ovf = (acc >> SUM_WIDTH) != '0;

    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next     = state_reg;
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        sum_next       = sum_reg;
        sat_next       = sat_reg;
        last_next      = last_reg;
        add_next       = add_reg;
        mag_next       = mag_reg;
        e_next         = e_reg;
        p_next         = p_reg;
        cnt_next       = cnt_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_len_next     = m_len_reg;
        m_sat_next     = m_sat_reg;
        s_tready       = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    mag_next       = (cur >= prev_reg) ? cur - prev_reg : prev_reg - cur;
                    add_next       = have_prev_reg;
                    last_next      = s_tlast;
                    prev_next      = cur;
                    have_prev_next = 1'b1;
                    e_next         = '0;
                    p_next         = '0;
                    cnt_next       = CNT_W'(FRAC_BITS);
                    if (have_prev_reg) begin
                        state_next = ST_ROOT;
                    end else if (s_tlast) begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_ROOT: begin
                if (p_try <= LIMIT) begin
                    e_next = e_reg | (ROOT_W'(1) << cnt_reg);
                    p_next = p_try;
                end
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0) begin
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM: begin
                if (add_reg) begin
                    if (acc_ovf) begin
                        sum_next = SUM_MAX;
                        sat_next = 1'b1;
                    end else begin
                        sum_next = acc[SUM_WIDTH-1:0];
                    end
                end
                state_next = last_reg ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_len_next     = sum_reg;
                    m_sat_next     = sat_reg;
                    sum_next       = '0;
                    sat_next       = 1'b0;
                    prev_next      = '0;
                    have_prev_next = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            sum_reg       <= '0;
            sat_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            prev_reg      <= prev_next;
            have_prev_reg <= have_prev_next;
            sum_reg       <= sum_next;
            sat_reg       <= sat_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        last_reg  <= last_next;
        add_reg   <= add_next;
        mag_reg   <= mag_next;
        e_reg     <= e_next;
        p_reg     <= p_next;
        cnt_reg   <= cnt_next;
        m_len_reg <= m_len_next;
        m_sat_reg <= m_sat_next;
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = TD_OUT_W'(m_len_reg);
    assign m_tuser[0] = m_sat_reg;

    // partial square never passes the bound
    a_root_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROOT) |-> (p_reg <= LIMIT))
        else $error("root partial product above bound");

    // the root loop runs until its bit counter reaches zero
    a_root_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROOT && cnt_reg != '0) |=> (state_reg == ST_ROOT))
        else $error("root loop left early");

    // a saturated result carries the clamped sum
    a_sat_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_sat_reg) |-> (m_len_reg == SUM_MAX))
        else $error("saturated result not at full scale");

    // emitting a result clears the sequence state
    a_emit_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && out_free) |=>
            (sum_reg == '0 && !sat_reg && !have_prev_reg && m_valid_reg))
        else $error("sequence state not cleared after result");

    // no input item is taken while one is in work
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("ready while busy");

endmodule
